// ===== hw/rtl/tem_pkg.sv =====
package tem_pkg;

    // Default parameter values.
    localparam int TEM_MAX_ELEMENTS = 16777216;
    localparam int TEM_DATA_WIDTH   = 16;

    // Queue between the accumulating front end and the arithmetic back end.
    localparam int TEM_Q_DEPTH = 2;
    localparam int TEM_Q_LVL_W = $clog2(TEM_Q_DEPTH + 1);

    // Result word field widths.
    localparam int TEM_MSE_W  = 32;
    localparam int TEM_MAE_W  = 16;
    localparam int TEM_COS_W  = 16;
    localparam int TEM_PEAK_W = 16;
    localparam int TEM_ELEM_W = 25;

    // Cosine is Q2.14; the squared ratio is at most 2^28, its root at most 2^14.
    localparam int TEM_COS_FRAC = 14;
    localparam int TEM_QC_W     = 2 * TEM_COS_FRAC + 1;
    localparam int TEM_ROOT_W   = TEM_COS_FRAC + 1;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_X,
        S_DIV_SQ,
        S_DIV_ABS,
        S_DIV_COS,
        S_SQRT,
        S_FIN
    } t_back_state;

    // Accumulator widths that follow from the sample width and the element limit.
    function automatic int cnt_w(input int max_el);
        return $clog2(max_el + 1);
    endfunction

    function automatic int sq_w(input int dw, input int max_el);
        return 2 * dw + cnt_w(max_el);
    endfunction

    function automatic int abs_w(input int dw, input int max_el);
        return dw + cnt_w(max_el);
    endfunction

    function automatic int dot_w(input int dw, input int max_el);
        return 2 * dw + cnt_w(max_el);
    endfunction

    function automatic int nrm_w(input int dw, input int max_el);
        return 2 * dw - 1 + cnt_w(max_el);
    endfunction

    function automatic int snap_w(input int dw, input int max_el);
        return sq_w(dw, max_el) + abs_w(dw, max_el) + dot_w(dw, max_el)
            + 2 * nrm_w(dw, max_el) + dw + cnt_w(max_el) + 1;
    endfunction

endpackage

// ===== hw/rtl/tem_if.sv =====
// Input channel: one element pair per word.
interface tem_in_if #(
    parameter int DATA_WIDTH = tem_pkg::TEM_DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_a;
    logic signed [DATA_WIDTH-1:0] sample_b;
    logic                         last;

    modport source (output valid, output sample_a, output sample_b, output last,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input last,
                    output ready);
endinterface

// Output channel: one metrics word per tensor.
interface tem_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic        [tem_pkg::TEM_MSE_W-1:0]  mean_sq_error;
    logic        [tem_pkg::TEM_MAE_W-1:0]  mean_abs_error;
    logic signed [tem_pkg::TEM_COS_W-1:0]  cosine_sim;
    logic        [tem_pkg::TEM_PEAK_W-1:0] peak_error;
    logic        [tem_pkg::TEM_ELEM_W-1:0] elements_seen;
    logic                                 overflow;

    modport source (output valid, output mean_sq_error, output mean_abs_error,
                    output cosine_sim, output peak_error, output elements_seen,
                    output overflow, input ready);
    modport sink   (input valid, input mean_sq_error, input mean_abs_error,
                    input cosine_sim, input peak_error, input elements_seen,
                    input overflow, output ready);
endinterface

// ===== hw/rtl/tem_fifo.sv =====
module tem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tem_pkg::TEM_Q_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [LVL_W-1:0] r_level;
    logic             w_do_pop;

    // Pop only what is there.
    assign w_do_pop = i_pop && (r_level != '0);

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_level <= r_level + LVL_W'(i_push) - LVL_W'(w_do_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_level;

endmodule

// ===== hw/rtl/tem_front.sv =====
module tem_front #(
    parameter int MAX_ELEMENTS = tem_pkg::TEM_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = tem_pkg::TEM_DATA_WIDTH
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    tem_in_if.sink                                       i_in,
    input  logic [tem_pkg::TEM_Q_LVL_W-1:0]              i_q_level,
    output logic                                         o_push,
    output logic [tem_pkg::snap_w(DATA_WIDTH, MAX_ELEMENTS)-1:0] o_snap
);
    localparam int DW     = DATA_WIDTH;
    localparam int CNT_W  = tem_pkg::cnt_w(MAX_ELEMENTS);
    localparam int SQ_W   = tem_pkg::sq_w(DW, MAX_ELEMENTS);
    localparam int ABS_W  = tem_pkg::abs_w(DW, MAX_ELEMENTS);
    localparam int DOT_W  = tem_pkg::dot_w(DW, MAX_ELEMENTS);
    localparam int NRM_W  = tem_pkg::nrm_w(DW, MAX_ELEMENTS);
    localparam int LVL1_W = tem_pkg::TEM_Q_LVL_W + 1;

    // Item terms.
    logic signed [DW:0]     w_diff;
    logic [DW-1:0]          w_ad;
    logic [2*DW-1:0]        w_sq;
    logic signed [2*DW-1:0] w_dot;
    logic signed [2*DW-1:0] w_na;
    logic signed [2*DW-1:0] w_nb;
    logic                   w_accept;
    logic                   w_counted;
    logic [CNT_W-1:0]       w_cnt_after;
    logic                   w_pend;

    // Element count at the input side.
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    // Product stage.
    logic                   r_s1_v;
    logic                   r_s1_last;
    logic                   r_s1_used;
    logic [DW-1:0]          r_s1_ad;
    logic [2*DW-1:0]        r_s1_sq;
    logic signed [2*DW-1:0] r_s1_dot;
    logic [2*DW-2:0]        r_s1_na;
    logic [2*DW-2:0]        r_s1_nb;
    logic [CNT_W-1:0]       r_s1_cnt;
    logic                   r_s1_ovf;

    // Running sums.
    logic [SQ_W-1:0]         r_sq;
    logic [ABS_W-1:0]        r_abs;
    logic signed [DOT_W-1:0] r_dot;
    logic [NRM_W-1:0]        r_na;
    logic [NRM_W-1:0]        r_nb;
    logic [DW-1:0]           r_peak;

    logic [SQ_W-1:0]         n_sq;
    logic [ABS_W-1:0]        n_abs;
    logic signed [DOT_W-1:0] n_dot;
    logic [NRM_W-1:0]        n_na;
    logic [NRM_W-1:0]        n_nb;
    logic [DW-1:0]           n_peak;

    // Hold off input while a pending last word might not find a queue slot.
    assign w_pend     = r_s1_v && r_s1_last;
    assign i_in.ready = (LVL1_W'(i_q_level) + LVL1_W'(w_pend)) <
                        LVL1_W'(tem_pkg::TEM_Q_DEPTH);
    assign w_accept   = i_in.valid && i_in.ready;

    // Difference, its magnitude and the products of one pair.
    assign w_diff = {i_in.sample_a[DW-1], i_in.sample_a} -
                    {i_in.sample_b[DW-1], i_in.sample_b};
    assign w_ad   = w_diff[DW] ? DW'(-w_diff) : w_diff[DW-1:0];
    assign w_sq   = w_ad * w_ad;
    assign w_dot  = i_in.sample_a * i_in.sample_b;
    assign w_na   = i_in.sample_a * i_in.sample_a;
    assign w_nb   = i_in.sample_b * i_in.sample_b;

    // Pairs beyond the count limit are dropped and flag overflow.
    assign w_counted   = (r_cnt < CNT_W'(MAX_ELEMENTS));
    assign w_cnt_after = w_counted ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            if (w_accept) begin
                r_cnt <= i_in.last ? '0 : w_cnt_after;
                r_ovf <= i_in.last ? 1'b0 : (r_ovf || !w_counted);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last <= i_in.last;
            r_s1_used <= w_counted;
            r_s1_ad   <= w_ad;
            r_s1_sq   <= w_sq;
            r_s1_dot  <= w_dot;
            r_s1_na   <= w_na[2*DW-2:0];
            r_s1_nb   <= w_nb[2*DW-2:0];
            r_s1_cnt  <= w_cnt_after;
            r_s1_ovf  <= r_ovf || !w_counted;
        end
    end

    // Accumulate the registered terms.
    always_comb begin
        n_sq   = r_sq;
        n_abs  = r_abs;
        n_dot  = r_dot;
        n_na   = r_na;
        n_nb   = r_nb;
        n_peak = r_peak;
        if (r_s1_v && r_s1_used) begin
            n_sq   = r_sq + SQ_W'(r_s1_sq);
            n_abs  = r_abs + ABS_W'(r_s1_ad);
            n_dot  = r_dot + DOT_W'(r_s1_dot);
            n_na   = r_na + NRM_W'(r_s1_na);
            n_nb   = r_nb + NRM_W'(r_s1_nb);
            n_peak = (r_s1_ad > r_peak) ? r_s1_ad : r_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_sq   <= '0;
            r_abs  <= '0;
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_peak <= '0;
        end else begin
            r_sq   <= n_sq;
            r_abs  <= n_abs;
            r_dot  <= n_dot;
            r_na   <= n_na;
            r_nb   <= n_nb;
            r_peak <= n_peak;
        end
    end

    // The last word hands the finished sums to the back end.
    assign o_push = r_s1_v && r_s1_last;
    assign o_snap = {n_sq, n_abs, n_dot, n_na, n_nb, n_peak, r_s1_cnt, r_s1_ovf};

endmodule

// ===== hw/rtl/tem_back.sv =====
module tem_back #(
    parameter int MAX_ELEMENTS = tem_pkg::TEM_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = tem_pkg::TEM_DATA_WIDTH
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_q_valid,
    input  logic [tem_pkg::snap_w(DATA_WIDTH, MAX_ELEMENTS)-1:0] i_q_data,
    output logic                                                 o_pop,
    tem_out_if.source                                            o_out
);
    localparam int DW     = DATA_WIDTH;
    localparam int CNT_W  = tem_pkg::cnt_w(MAX_ELEMENTS);
    localparam int SQ_W   = tem_pkg::sq_w(DW, MAX_ELEMENTS);
    localparam int ABS_W  = tem_pkg::abs_w(DW, MAX_ELEMENTS);
    localparam int DOT_W  = tem_pkg::dot_w(DW, MAX_ELEMENTS);
    localparam int NRM_W  = tem_pkg::nrm_w(DW, MAX_ELEMENTS);
    localparam int M_W    = DOT_W;
    localparam int P_W    = 2 * NRM_W;
    localparam int FRAC2  = 2 * tem_pkg::TEM_COS_FRAC;
    localparam int DIV_W  = 2 * M_W + FRAC2;
    localparam int REM_W  = P_W + 1;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int QC_W   = tem_pkg::TEM_QC_W;
    localparam int ROOT_W = tem_pkg::TEM_ROOT_W;

    // Unpacked queue word.
    logic [SQ_W-1:0]         w_in_sq;
    logic [ABS_W-1:0]        w_in_abs;
    logic signed [DOT_W-1:0] w_in_dot;
    logic [NRM_W-1:0]        w_in_na;
    logic [NRM_W-1:0]        w_in_nb;
    logic [DW-1:0]           w_in_peak;
    logic [CNT_W-1:0]        w_in_cnt;
    logic                    w_in_ovf;

    assign {w_in_sq, w_in_abs, w_in_dot, w_in_na, w_in_nb, w_in_peak, w_in_cnt,
            w_in_ovf} = i_q_data;

    tem_pkg::t_back_state r_state, n_state;

    // Operands held for the current tensor.
    logic [SQ_W-1:0]  r_sq,   n_sq;
    logic [ABS_W-1:0] r_abs,  n_abs;
    logic [M_W-1:0]   r_mag,  n_mag;
    logic             r_neg,  n_neg;
    logic             r_zero, n_zero;
    logic [DW-1:0]    r_peak, n_peak;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_ovf,  n_ovf;
    logic [P_W-1:0]   r_p,    n_p;
    logic [DIV_W-1:0] r_x,    n_x;

    // Shift-add multiplier.
    logic [2*M_W-1:0] r_m_acc, n_m_acc;
    logic [2*M_W-1:0] r_m_a,   n_m_a;
    logic [M_W-1:0]   r_m_b,   n_m_b;
    logic [2*M_W-1:0] w_m_acc;

    // Restoring divider, one quotient bit per cycle.
    logic [REM_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [P_W-1:0]   r_dvs, n_dvs;
    logic [REM_W-1:0] w_rem_sh;
    logic             w_ge;
    logic [REM_W-1:0] w_rem_n;
    logic [DIV_W-1:0] w_dvd_n;

    // Bitwise integer square root.
    logic [QC_W-1:0]     r_qc,   n_qc;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [ROOT_W-1:0]   r_sbit, n_sbit;
    logic [ROOT_W-1:0]   w_cand;
    logic [2*ROOT_W-1:0] w_cand_sq;

    logic [STEP_W-1:0] r_step, n_step;

    // Quotients and output register.
    logic [tem_pkg::TEM_MSE_W-1:0]         r_q_sq,  n_q_sq;
    logic [tem_pkg::TEM_MAE_W-1:0]         r_q_abs, n_q_abs;
    logic                                  r_out_v, n_out_v;
    logic [tem_pkg::TEM_MSE_W-1:0]         r_o_mse, n_o_mse;
    logic [tem_pkg::TEM_MAE_W-1:0]         r_o_mae, n_o_mae;
    logic signed [tem_pkg::TEM_COS_W-1:0]  r_o_cos, n_o_cos;
    logic [tem_pkg::TEM_PEAK_W-1:0]        r_o_peak, n_o_peak;
    logic [tem_pkg::TEM_ELEM_W-1:0]        r_o_elem, n_o_elem;
    logic                                  r_o_ovf, n_o_ovf;

    // Datapath steps.
    assign w_m_acc   = r_m_b[0] ? r_m_acc + r_m_a : r_m_acc;
    assign w_rem_sh  = {r_rem[REM_W-2:0], r_dvd[DIV_W-1]};
    assign w_ge      = (w_rem_sh >= REM_W'(r_dvs));
    assign w_rem_n   = w_ge ? w_rem_sh - REM_W'(r_dvs) : w_rem_sh;
    assign w_dvd_n   = {r_dvd[DIV_W-2:0], w_ge};
    assign w_cand    = r_root | r_sbit;
    assign w_cand_sq = w_cand * w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tem_pkg::S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq     <= n_sq;
        r_abs    <= n_abs;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_zero   <= n_zero;
        r_peak   <= n_peak;
        r_cnt    <= n_cnt;
        r_ovf    <= n_ovf;
        r_p      <= n_p;
        r_x      <= n_x;
        r_m_acc  <= n_m_acc;
        r_m_a    <= n_m_a;
        r_m_b    <= n_m_b;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_dvs    <= n_dvs;
        r_qc     <= n_qc;
        r_root   <= n_root;
        r_sbit   <= n_sbit;
        r_step   <= n_step;
        r_q_sq   <= n_q_sq;
        r_q_abs  <= n_q_abs;
        r_o_mse  <= n_o_mse;
        r_o_mae  <= n_o_mae;
        r_o_cos  <= n_o_cos;
        r_o_peak <= n_o_peak;
        r_o_elem <= n_o_elem;
        r_o_ovf  <= n_o_ovf;
    end

    // Sequencer: two products, two or three divisions, 0 or 1 root, the result.
    always_comb begin
        n_state  = r_state;
        n_sq     = r_sq;
        n_abs    = r_abs;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_zero   = r_zero;
        n_peak   = r_peak;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_p      = r_p;
        n_x      = r_x;
        n_m_acc  = r_m_acc;
        n_m_a    = r_m_a;
        n_m_b    = r_m_b;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_dvs    = r_dvs;
        n_qc     = r_qc;
        n_root   = r_root;
        n_sbit   = r_sbit;
        n_step   = r_step;
        n_q_sq   = r_q_sq;
        n_q_abs  = r_q_abs;
        n_o_mse  = r_o_mse;
        n_o_mae  = r_o_mae;
        n_o_cos  = r_o_cos;
        n_o_peak = r_o_peak;
        n_o_elem = r_o_elem;
        n_o_ovf  = r_o_ovf;
        n_out_v  = r_out_v && !o_out.ready;
        o_pop    = 1'b0;

        unique case (r_state)
            tem_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_sq    = w_in_sq;
                    n_abs   = w_in_abs;
                    n_mag   = w_in_dot[DOT_W-1] ? M_W'(-w_in_dot) : M_W'(w_in_dot);
                    n_neg   = w_in_dot[DOT_W-1];
                    n_zero  = (w_in_na == '0) || (w_in_nb == '0);
                    n_peak  = w_in_peak;
                    n_cnt   = w_in_cnt;
                    n_ovf   = w_in_ovf;
                    n_m_acc = '0;
                    n_m_a   = (2*M_W)'(w_in_na);
                    n_m_b   = M_W'(w_in_nb);
                    n_step  = '0;
                    n_state = tem_pkg::S_MUL_P;
                end
            end
            tem_pkg::S_MUL_P: begin
                n_m_acc = w_m_acc;
                n_m_a   = r_m_a << 1;
                n_m_b   = r_m_b >> 1;
                n_step  = r_step + 1'b1;
                if (r_step == STEP_W'(M_W - 1)) begin
                    n_p     = w_m_acc[P_W-1:0];
                    n_m_acc = '0;
                    n_m_a   = (2*M_W)'(r_mag);
                    n_m_b   = r_mag;
                    n_step  = '0;
                    n_state = tem_pkg::S_MUL_X;
                end
            end
            tem_pkg::S_MUL_X: begin
                n_m_acc = w_m_acc;
                n_m_a   = r_m_a << 1;
                n_m_b   = r_m_b >> 1;
                n_step  = r_step + 1'b1;
                if (r_step == STEP_W'(M_W - 1)) begin
                    n_x     = {w_m_acc, {FRAC2{1'b0}}};
                    n_rem   = '0;
                    n_dvd   = DIV_W'(r_sq) << (DIV_W - SQ_W);
                    n_dvs   = P_W'(r_cnt);
                    n_step  = '0;
                    n_state = tem_pkg::S_DIV_SQ;
                end
            end
            tem_pkg::S_DIV_SQ: begin
                n_rem  = w_rem_n;
                n_dvd  = w_dvd_n;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SQ_W - 1)) begin
                    n_q_sq  = w_dvd_n[tem_pkg::TEM_MSE_W-1:0];
                    n_rem   = '0;
                    n_dvd   = DIV_W'(r_abs) << (DIV_W - ABS_W);
                    n_step  = '0;
                    n_state = tem_pkg::S_DIV_ABS;
                end
            end
            tem_pkg::S_DIV_ABS: begin
                n_rem  = w_rem_n;
                n_dvd  = w_dvd_n;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(ABS_W - 1)) begin
                    n_q_abs = w_dvd_n[tem_pkg::TEM_MAE_W-1:0];
                    n_step  = '0;
                    if (r_zero) begin
                        // A zero norm gives a cosine of zero.
                        n_root  = '0;
                        n_state = tem_pkg::S_FIN;
                    end else begin
                        n_rem   = '0;
                        n_dvd   = r_x;
                        n_dvs   = r_p;
                        n_state = tem_pkg::S_DIV_COS;
                    end
                end
            end
            tem_pkg::S_DIV_COS: begin
                n_rem  = w_rem_n;
                n_dvd  = w_dvd_n;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_qc    = w_dvd_n[QC_W-1:0];
                    n_root  = '0;
                    n_sbit  = {1'b1, {(ROOT_W-1){1'b0}}};
                    n_step  = '0;
                    n_state = tem_pkg::S_SQRT;
                end
            end
            tem_pkg::S_SQRT: begin
                if (w_cand_sq <= (2*ROOT_W)'(r_qc)) begin
                    n_root = w_cand;
                end
                n_sbit = r_sbit >> 1;
                if (r_sbit[0]) begin
                    n_state = tem_pkg::S_FIN;
                end
            end
            tem_pkg::S_FIN: begin
                // Load the output register once it is free.
                if (!r_out_v || o_out.ready) begin
                    n_out_v  = 1'b1;
                    n_o_mse  = r_q_sq;
                    n_o_mae  = r_q_abs;
                    n_o_cos  = r_neg ? -tem_pkg::TEM_COS_W'(r_root)
                                     : tem_pkg::TEM_COS_W'(r_root);
                    n_o_peak = tem_pkg::TEM_PEAK_W'(r_peak);
                    n_o_elem = tem_pkg::TEM_ELEM_W'(r_cnt);
                    n_o_ovf  = r_ovf;
                    n_state  = tem_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tem_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out.valid          = r_out_v;
    assign o_out.mean_sq_error  = r_o_mse;
    assign o_out.mean_abs_error = r_o_mae;
    assign o_out.cosine_sim     = r_o_cos;
    assign o_out.peak_error     = r_o_peak;
    assign o_out.elements_seen  = r_o_elem;
    assign o_out.overflow       = r_o_ovf;

endmodule

// ===== hw/rtl/tensor_error_metrics.sv =====
// Streaming error metrics between a reference tensor and a test tensor.
// Input channel i_in carries one element pair (sample_a, sample_b, signed Q8.8)
// and a last flag per word. The front end takes one word per cycle while it
// is ready, forms the difference and products in one registered stage and
// adds them to running sums in the next. The word marked last closes the
// tensor: its sums go into a two-entry queue and the sums restart from zero.
// The back end turns each queued tensor into one word on o_out: mean squared
// error, mean absolute error, cosine similarity, peak error, count, overflow.
// It runs a shift-add multiplier and a restoring divider that both resolve
// one bit per cycle, then a bitwise square root. While the back end works
// on one tensor it takes no other from the queue, so short tensors
// back-pressure the input through i_in.ready once the queue is full. A stall
// on o_out holds the result word in the output register while the back end
// goes on with the next queued tensor.
// Reset clears all sums, the count, the queue and the output valid.
module tensor_error_metrics #(
    parameter int MAX_ELEMENTS = tem_pkg::TEM_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = tem_pkg::TEM_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tem_in_if.sink    i_in,
    tem_out_if.source o_out
);
    localparam int SNAP_W = tem_pkg::snap_w(DATA_WIDTH, MAX_ELEMENTS);

    logic                            w_push;
    logic [SNAP_W-1:0]               w_snap;
    logic [tem_pkg::TEM_Q_LVL_W-1:0] w_level;
    logic                            w_q_valid;
    logic [SNAP_W-1:0]               w_q_data;
    logic                            w_pop;

    // Accumulating front end.
    tem_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_level (w_level),
        .o_push    (w_push),
        .o_snap    (w_snap)
    );

    // Queue of finished tensor sums.
    tem_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (tem_pkg::TEM_Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_level (w_level)
    );

    // Division and root back end.
    tem_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    // A full queue must stop the input.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_level == tem_pkg::TEM_Q_LVL_W'(tem_pkg::TEM_Q_DEPTH)) |-> !i_in.ready)
        else $error("input accepted while the tensor queue is full");

    // The queue is never pushed while full unless it is popped in the same cycle.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_level != tem_pkg::TEM_Q_LVL_W'(tem_pkg::TEM_Q_DEPTH)) || w_pop)
        else $error("tensor queue overrun");

    // Cosine stays within plus and minus one.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.cosine_sim <= 16'sd16384) &&
                        (o_out.cosine_sim >= -16'sd16384))
        else $error("cosine out of range");

    // Every result word covers at least one element.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.elements_seen != '0))
        else $error("result word with zero elements");
`endif

endmodule
